### rtl/rrm_pkg.sv
// Shared constants and types for the register rename map.
package rrm_pkg;

   localparam int ARCH_REGS        = 32;
   localparam int PHYS_REGS        = 128;
   localparam int FIRST_FRESH      = 32;
   localparam int CHECKPOINT_SLOTS = 4;
   localparam int PHYS_W           = 7;
   localparam int ARCH_W           = 5;
   localparam int CNT_W            = 8;

   typedef logic [PHYS_W-1:0] phys_type;
   typedef logic [ARCH_W-1:0] arch_type;
   typedef logic [CNT_W-1:0]  cnt_type;

   typedef enum logic [2:0] {
      ACT_LOOK_SPEC = 3'd0,
      ACT_LOOK_ARCH = 3'd1,
      ACT_RENAME    = 3'd2,
      ACT_COMMIT    = 3'd3,
      ACT_SAVE      = 3'd4,
      ACT_RESTORE   = 3'd5,
      ACT_RESTORE_C = 3'd6,
      ACT_NOP       = 3'd7
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_LOOK,
      ST_SCAN,
      ST_CFIN,
      ST_COPY
   } state_type;

endpackage

### rtl/register_rename_map_core.sv
// Register rename map: speculative and committed maps, free stacks, checkpoints.
//
// Usage: drive req_action, req_arch_reg, req_phys_reg and req_slot with start
// high; the word is taken at the rising edge where start is high and busy is
// low. Exactly one result word follows per request on the rsp_ ports, marked
// by rsp_valid for a single cycle. The receiver cannot stall, so results are
// never held back; busy stays high until the strobe shows the result.
// Lookups and rename read the maps and answer from the look state; register
// zero, exhausted and ignored requests answer straight from the issue state.
// Commit walks both free stacks at one entry per cycle. Save, restore and
// restore-committed copy tables and stacks through synchronous memories with
// separate read and write ports, one entry per cycle. Only one request is in
// flight; the walk over stored entries sets the rate.
// Reset: synchronous, active high. Both maps read as identity through per
// entry valid bits, free counts clear, the fresh counter goes to 32, and all
// checkpoint slots are marked unsaved. No clearing pass is needed.
module register_rename_map_core #(
   parameter int SLOTS = rrm_pkg::CHECKPOINT_SLOTS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [2:0]            req_action,
   input  rrm_pkg::arch_type     req_arch_reg,
   input  rrm_pkg::phys_type     req_phys_reg,
   input  logic [1:0]            req_slot,
   output logic                  rsp_valid,
   output rrm_pkg::phys_type     rsp_result_phys,
   output rrm_pkg::phys_type     rsp_prior_phys,
   output rrm_pkg::phys_type     rsp_freed_phys,
   output logic                  rsp_exhausted
);

   import rrm_pkg::*;

   localparam int STW = $clog2(SLOTS * ARCH_REGS);
   localparam int SSW = $clog2(SLOTS * PHYS_REGS);
   localparam int SIW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int SPW = $clog2(PHYS_REGS);

   // memories
   phys_type spec_tab [ARCH_REGS];
   phys_type arch_tab [ARCH_REGS];
   phys_type spec_stk [PHYS_REGS];
   phys_type comm_stk [PHYS_REGS];
   phys_type save_tab [SLOTS*ARCH_REGS];
   phys_type save_stk [SLOTS*PHYS_REGS];

   // control state
   state_type        state_ff, state_in;
   action_type       act_ff, act_in;
   arch_type         arch_ff, arch_in;
   phys_type         phys_ff, phys_in;
   logic [1:0]       slot_ff, slot_in;
   cnt_type          spec_cnt_ff, spec_cnt_in;
   cnt_type          comm_cnt_ff, comm_cnt_in;
   cnt_type          fresh_ff, fresh_in;
   logic [ARCH_REGS-1:0] spec_tv_ff, arch_tv_ff;
   logic [SLOTS-1:0] slot_valid_ff;
   cnt_type          saved_cnt_ff   [SLOTS];
   cnt_type          saved_fresh_ff [SLOTS];
   cnt_type          idx_ff, idx_in;
   cnt_type          pidx_ff, pidx_in;
   logic             pend_ff, pend_in;
   cnt_type          len_ff, len_in;
   cnt_type          swr_ff, swr_in;
   cnt_type          cwr_ff, cwr_in;
   logic             sfound_ff, sfound_in;
   logic             cfound_ff, cfound_in;
   phys_type         old_ff, old_in;
   cnt_type          max_ff, max_in;
   logic             rsp_valid_ff, rsp_valid_in;
   phys_type         res_ff, res_in;
   phys_type         prev_ff, prev_in;
   phys_type         freed_ff, freed_in;
   logic             exh_ff, exh_in;
   logic             save_done;

   // memory ports
   arch_type             st_ra, at_ra, st_wa, at_wa;
   logic [SPW-1:0]       ss_ra, cs_ra, ss_wa, cs_wa;
   logic [STW-1:0]       vt_ra, vt_wa;
   logic [SSW-1:0]       vs_ra, vs_wa;
   logic                 st_we, at_we, ss_we, cs_we, vt_we, vs_we;
   phys_type             st_wd, at_wd, ss_wd, cs_wd, vt_wd, vs_wd;
   phys_type             st_q, at_q, ss_q, cs_q, vt_q, vs_q;
   logic                 st_qv, at_qv;
   arch_type             st_qa, at_qa;
   phys_type             st_val, at_val;

   logic                 slot_ok;
   logic [SIW-1:0]       sidx;
   logic [STW-1:0]       tab_base;
   logic [SSW-1:0]       stk_base;

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_phys   = res_ff;
   assign rsp_prior_phys    = prev_ff;
   assign rsp_freed_phys    = freed_ff;
   assign rsp_exhausted     = exh_ff;

   assign slot_ok  = (32'(slot_ff) < SLOTS);
   assign sidx     = SIW'(slot_ff);
   assign tab_base = STW'({slot_ff, 5'd0});
   assign stk_base = SSW'({slot_ff, 7'd0});

   // unwritten map entries read as identity
   assign st_val = st_qv ? st_q : PHYS_W'(st_qa);
   assign at_val = at_qv ? at_q : PHYS_W'(at_qa);

   // ---------------------------------------------------------------- memories
   always_ff @(posedge clock) begin
      if (st_we) spec_tab[st_wa] <= st_wd;
      st_q  <= spec_tab[st_ra];
      st_qv <= spec_tv_ff[st_ra];
      st_qa <= st_ra;
   end

   always_ff @(posedge clock) begin
      if (at_we) arch_tab[at_wa] <= at_wd;
      at_q  <= arch_tab[at_ra];
      at_qv <= arch_tv_ff[at_ra];
      at_qa <= at_ra;
   end

   always_ff @(posedge clock) begin
      if (ss_we) spec_stk[ss_wa] <= ss_wd;
      ss_q <= spec_stk[ss_ra];
   end

   always_ff @(posedge clock) begin
      if (cs_we) comm_stk[cs_wa] <= cs_wd;
      cs_q <= comm_stk[cs_ra];
   end

   always_ff @(posedge clock) begin
      if (vt_we) save_tab[vt_wa] <= vt_wd;
      vt_q <= save_tab[vt_ra];
   end

   always_ff @(posedge clock) begin
      if (vs_we) save_stk[vs_wa] <= vs_wd;
      vs_q <= save_stk[vs_ra];
   end

   // checkpoint counters: payload, no reset
   always_ff @(posedge clock) begin
      if (save_done) begin
         saved_cnt_ff[sidx]   <= spec_cnt_ff;
         saved_fresh_ff[sidx] <= fresh_ff;
      end
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         spec_cnt_ff   <= '0;
         comm_cnt_ff   <= '0;
         fresh_ff      <= CNT_W'(FIRST_FRESH);
         spec_tv_ff    <= '0;
         arch_tv_ff    <= '0;
         slot_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         pend_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         spec_cnt_ff  <= spec_cnt_in;
         comm_cnt_ff  <= comm_cnt_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
         if (st_we) spec_tv_ff[st_wa] <= 1'b1;
         if (at_we) arch_tv_ff[at_wa] <= 1'b1;
         if (save_done) slot_valid_ff[sidx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      act_ff    <= act_in;
      arch_ff   <= arch_in;
      phys_ff   <= phys_in;
      slot_ff   <= slot_in;
      idx_ff    <= idx_in;
      pidx_ff   <= pidx_in;
      len_ff    <= len_in;
      swr_ff    <= swr_in;
      cwr_ff    <= cwr_in;
      sfound_ff <= sfound_in;
      cfound_ff <= cfound_in;
      old_ff    <= old_in;
      max_ff    <= max_in;
      res_ff    <= res_in;
      prev_ff   <= prev_in;
      freed_ff  <= freed_in;
      exh_ff    <= exh_in;
   end

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      cnt_type  total;
      cnt_type  scan_len;
      cnt_type  m;
      logic     recycle;

      state_in     = state_ff;
      act_in       = act_ff;
      arch_in      = arch_ff;
      phys_in      = phys_ff;
      slot_in      = slot_ff;
      spec_cnt_in  = spec_cnt_ff;
      comm_cnt_in  = comm_cnt_ff;
      fresh_in     = fresh_ff;
      idx_in       = idx_ff;
      pidx_in      = pidx_ff;
      pend_in      = 1'b0;
      len_in       = len_ff;
      swr_in       = swr_ff;
      cwr_in       = cwr_ff;
      sfound_in    = sfound_ff;
      cfound_in    = cfound_ff;
      old_in       = old_ff;
      max_in       = max_ff;
      rsp_valid_in = 1'b0;
      res_in       = res_ff;
      prev_in      = prev_ff;
      freed_in     = freed_ff;
      exh_in       = exh_ff;
      save_done    = 1'b0;

      st_ra = arch_ff;  at_ra = arch_ff;
      ss_ra = '0;       cs_ra = '0;
      vt_ra = tab_base; vs_ra = stk_base;
      st_we = 1'b0; st_wa = '0; st_wd = '0;
      at_we = 1'b0; at_wa = '0; at_wd = '0;
      ss_we = 1'b0; ss_wa = '0; ss_wd = '0;
      cs_we = 1'b0; cs_wa = '0; cs_wd = '0;
      vt_we = 1'b0; vt_wa = '0; vt_wd = '0;
      vs_we = 1'b0; vs_wa = '0; vs_wd = '0;

      total    = (len_ff > CNT_W'(ARCH_REGS)) ? len_ff : CNT_W'(ARCH_REGS);
      scan_len = (spec_cnt_ff > comm_cnt_ff) ? spec_cnt_ff : comm_cnt_ff;
      m        = max_ff;
      recycle  = (old_ff != '0) && (old_ff != phys_ff);

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               act_in   = action_type'(req_action);
               arch_in  = req_arch_reg;
               phys_in  = req_phys_reg;
               slot_in  = req_slot;
               res_in   = '0;
               prev_in  = '0;
               freed_in = '0;
               exh_in   = 1'b0;
               state_in = ST_ISSUE;
            end
         end

         ST_ISSUE: begin
            idx_in    = '0;
            swr_in    = '0;
            cwr_in    = '0;
            sfound_in = 1'b0;
            cfound_in = 1'b0;
            max_in    = CNT_W'(FIRST_FRESH);
            case (act_ff)
               ACT_LOOK_SPEC, ACT_LOOK_ARCH: state_in = ST_LOOK;
               ACT_RENAME: begin
                  if (arch_ff == '0) begin
                     rsp_valid_in = 1'b1;
                     state_in     = ST_IDLE;
                  end else if (spec_cnt_ff == '0 &&
                               fresh_ff >= CNT_W'(PHYS_REGS)) begin
                     exh_in       = 1'b1;
                     rsp_valid_in = 1'b1;
                     state_in     = ST_IDLE;
                  end else begin
                     ss_ra    = SPW'(spec_cnt_ff - 1'b1);
                     state_in = ST_LOOK;
                  end
               end
               ACT_COMMIT: begin
                  if (arch_ff == '0) begin
                     rsp_valid_in = 1'b1;
                     state_in     = ST_IDLE;
                  end else begin
                     state_in = ST_LOOK;
                  end
               end
               ACT_SAVE: begin
                  len_in = spec_cnt_ff;
                  if (slot_ok) begin
                     state_in = ST_COPY;
                  end else begin
                     rsp_valid_in = 1'b1;
                     state_in     = ST_IDLE;
                  end
               end
               ACT_RESTORE: begin
                  if (slot_ok && slot_valid_ff[sidx]) begin
                     len_in   = saved_cnt_ff[sidx];
                     state_in = ST_COPY;
                  end else begin
                     rsp_valid_in = 1'b1;
                     state_in     = ST_IDLE;
                  end
               end
               ACT_RESTORE_C: begin
                  len_in   = comm_cnt_ff;
                  state_in = ST_COPY;
               end
               default: begin
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            endcase
         end

         ST_LOOK: begin
            case (act_ff)
               ACT_LOOK_SPEC: begin
                  res_in       = st_val;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
               ACT_LOOK_ARCH: begin
                  res_in       = at_val;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
               ACT_RENAME: begin
                  // pop the free stack, else hand out a fresh number
                  if (spec_cnt_ff != '0) begin
                     res_in      = ss_q;
                     st_wd       = ss_q;
                     spec_cnt_in = spec_cnt_ff - 1'b1;
                  end else begin
                     res_in   = fresh_ff[PHYS_W-1:0];
                     st_wd    = fresh_ff[PHYS_W-1:0];
                     fresh_in = fresh_ff + 1'b1;
                  end
                  prev_in      = st_val;
                  st_we        = 1'b1;
                  st_wa        = arch_ff;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
               ACT_COMMIT: begin
                  old_in   = at_val;
                  state_in = ST_SCAN;
               end
               default: begin
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            endcase
         end

         ST_SCAN: begin
            // compact both stacks in place, dropping the committed register
            if (idx_ff < scan_len) begin
               ss_ra   = SPW'(idx_ff);
               cs_ra   = SPW'(idx_ff);
               pidx_in = idx_ff;
               idx_in  = idx_ff + 1'b1;
               pend_in = 1'b1;
            end
            if (pend_ff) begin
               if (pidx_ff < spec_cnt_ff) begin
                  if (ss_q != phys_ff) begin
                     ss_we  = 1'b1;
                     ss_wa  = SPW'(swr_ff);
                     ss_wd  = ss_q;
                     swr_in = swr_ff + 1'b1;
                  end
                  if (ss_q == old_ff) sfound_in = 1'b1;
               end
               if (pidx_ff < comm_cnt_ff) begin
                  if (cs_q != phys_ff) begin
                     cs_we  = 1'b1;
                     cs_wa  = SPW'(cwr_ff);
                     cs_wd  = cs_q;
                     cwr_in = cwr_ff + 1'b1;
                  end
                  if (cs_q == old_ff) cfound_in = 1'b1;
               end
            end
            if (idx_ff >= scan_len && !pend_ff) state_in = ST_CFIN;
         end

         ST_CFIN: begin
            at_we       = 1'b1;
            at_wa       = arch_ff;
            at_wd       = phys_ff;
            spec_cnt_in = swr_ff;
            comm_cnt_in = cwr_ff;
            if (recycle) begin
               freed_in = old_ff;
               if (!sfound_ff && swr_ff < CNT_W'(PHYS_REGS)) begin
                  ss_we       = 1'b1;
                  ss_wa       = SPW'(swr_ff);
                  ss_wd       = old_ff;
                  spec_cnt_in = swr_ff + 1'b1;
               end
               if (!cfound_ff && cwr_ff < CNT_W'(PHYS_REGS)) begin
                  cs_we       = 1'b1;
                  cs_wa       = SPW'(cwr_ff);
                  cs_wd       = old_ff;
                  comm_cnt_in = cwr_ff + 1'b1;
               end
            end
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end

         ST_COPY: begin
            // issue entry idx, write back entry pidx read in the previous cycle
            if (idx_ff < total) begin
               st_ra   = ARCH_W'(idx_ff);
               at_ra   = ARCH_W'(idx_ff);
               ss_ra   = SPW'(idx_ff);
               cs_ra   = SPW'(idx_ff);
               vt_ra   = tab_base + STW'(idx_ff[ARCH_W-1:0]);
               vs_ra   = stk_base + SSW'(idx_ff[SPW-1:0]);
               pidx_in = idx_ff;
               idx_in  = idx_ff + 1'b1;
               pend_in = 1'b1;
            end
            if (pend_ff) begin
               if (pidx_ff < CNT_W'(ARCH_REGS)) begin
                  case (act_ff)
                     ACT_SAVE: begin
                        vt_we = 1'b1;
                        vt_wa = tab_base + STW'(pidx_ff[ARCH_W-1:0]);
                        vt_wd = st_val;
                     end
                     ACT_RESTORE: begin
                        st_we = 1'b1;
                        st_wa = ARCH_W'(pidx_ff);
                        st_wd = vt_q;
                     end
                     default: begin
                        st_we = 1'b1;
                        st_wa = ARCH_W'(pidx_ff);
                        st_wd = at_val;
                        if (CNT_W'(at_val) >= m) m = CNT_W'(at_val) + 1'b1;
                     end
                  endcase
               end
               if (pidx_ff < len_ff) begin
                  case (act_ff)
                     ACT_SAVE: begin
                        vs_we = 1'b1;
                        vs_wa = stk_base + SSW'(pidx_ff[SPW-1:0]);
                        vs_wd = ss_q;
                     end
                     ACT_RESTORE: begin
                        ss_we = 1'b1;
                        ss_wa = SPW'(pidx_ff);
                        ss_wd = vs_q;
                     end
                     default: begin
                        ss_we = 1'b1;
                        ss_wa = SPW'(pidx_ff);
                        ss_wd = cs_q;
                        if (CNT_W'(cs_q) >= m) m = CNT_W'(cs_q) + 1'b1;
                     end
                  endcase
               end
               max_in = m;
            end
            if (idx_ff >= total && !pend_ff) begin
               case (act_ff)
                  ACT_SAVE:    save_done = 1'b1;
                  ACT_RESTORE: begin
                     spec_cnt_in = saved_cnt_ff[sidx];
                     fresh_in    = saved_fresh_ff[sidx];
                  end
                  default: begin
                     spec_cnt_in = comm_cnt_ff;
                     fresh_in    = max_ff;
                  end
               endcase
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- checks
   a_done_strobe: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy dropped without a result word");

   a_one_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for two cycles");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (spec_cnt_ff <= CNT_W'(PHYS_REGS)) && (comm_cnt_ff <= CNT_W'(PHYS_REGS)))
      else $error("free count beyond stack depth");

   a_exh_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_exhausted |-> rsp_result_phys == '0 && rsp_prior_phys == '0)
      else $error("exhausted rename returned a register");

endmodule
